@@ hw/rtl/pbfct_pkg.sv @@
package pbfct_pkg;

	localparam int CMP_BITS = 64;
	localparam int REG_DATA_BITS = 32;
	localparam int REG_ADDR_BITS = 3;

	localparam logic REG_SKIP_COUNT = 1'b0;
	localparam logic REG_DONE_MASK = 1'b1;

	localparam logic [REG_DATA_BITS-1:0] SKIP_COUNT_RESET = 32'h0000_0000;
	localparam logic [REG_DATA_BITS-1:0] DONE_MASK_RESET = 32'hffff_ffff;

	localparam int BIT_INDEX_BITS = 5;
	localparam int CLOCK_BITS = 32;

	typedef struct packed {
		logic count;
		logic load_ref;
		logic watch;
		logic rep_step;
		logic clear;
	} dp_cmd_t;

	typedef struct packed {
		logic skip_le1;
		logic skip_reached;
		logic done_hit;
		logic rep_last;
	} dp_sts_t;

endpackage

@@ hw/rtl/pbfct_regs.sv @@
module pbfct_regs (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic [pbfct_pkg::REG_ADDR_BITS-1:0]  paddr,
	input  logic [pbfct_pkg::REG_DATA_BITS-1:0]  pwdata,
	output logic [pbfct_pkg::REG_DATA_BITS-1:0]  prdata,
	output logic                                  pready,
	output logic [pbfct_pkg::REG_DATA_BITS-1:0]  skip_count,
	output logic [pbfct_pkg::REG_DATA_BITS-1:0]  done_mask
);

	logic [pbfct_pkg::REG_DATA_BITS-1:0] skip_q;
	logic [pbfct_pkg::REG_DATA_BITS-1:0] done_q;
	logic                                wr_en;
	logic                                reg_sel;

	assign pready = 1'b1;
	assign reg_sel = paddr[2];
	assign wr_en = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skip_q <= pbfct_pkg::SKIP_COUNT_RESET;
			done_q <= pbfct_pkg::DONE_MASK_RESET;
		end else if (wr_en) begin
			case (reg_sel)
				pbfct_pkg::REG_SKIP_COUNT: skip_q <= pwdata;
				pbfct_pkg::REG_DONE_MASK:  done_q <= pwdata;
				default:                   skip_q <= skip_q;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			pbfct_pkg::REG_SKIP_COUNT: prdata = skip_q;
			pbfct_pkg::REG_DONE_MASK:  prdata = done_q;
			default:                   prdata = '0;
		endcase
	end

	assign skip_count = skip_q;
	assign done_mask = done_q;

endmodule

@@ hw/rtl/pbfct_ctrl.sv @@
module pbfct_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 command,
	output logic                 out_valid,
	input  logic                 out_ready,
	output pbfct_pkg::dp_cmd_t   cmd,
	input  pbfct_pkg::dp_sts_t   sts
);

	localparam logic ST_RUN = 1'b0;
	localparam logic ST_REPORT = 1'b1;

	localparam logic [1:0] PH_AWAIT = 2'd0;
	localparam logic [1:0] PH_SKIP = 2'd1;
	localparam logic [1:0] PH_WATCH = 2'd2;

	logic       st_q;
	logic       st_d;
	logic [1:0] phase_q;
	logic [1:0] phase_d;
	logic       in_beat;

	assign in_ready = (st_q == ST_RUN);
	assign out_valid = (st_q == ST_REPORT);
	assign in_beat = in_valid & in_ready;

	always_comb begin
		st_d = st_q;
		phase_d = phase_q;
		cmd = '0;
		case (st_q)
			ST_RUN: begin
				if (in_beat) begin
					if (command) begin
						st_d = ST_REPORT;
					end else begin
						cmd.count = 1'b1;
						case (phase_q)
							PH_AWAIT: begin
								cmd.load_ref = 1'b1;
								phase_d = sts.skip_le1 ? PH_WATCH : PH_SKIP;
							end
							PH_SKIP: begin
								cmd.load_ref = 1'b1;
								if (sts.skip_reached) begin
									phase_d = PH_WATCH;
								end
							end
							default: begin
								cmd.watch = 1'b1;
								if (sts.done_hit) begin
									st_d = ST_REPORT;
								end
							end
						endcase
					end
				end
			end
			ST_REPORT: begin
				if (out_ready) begin
					cmd.rep_step = 1'b1;
					if (sts.rep_last) begin
						cmd.clear = 1'b1;
						phase_d = PH_AWAIT;
						st_d = ST_RUN;
					end
				end
			end
			default: begin
				st_d = ST_RUN;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_RUN;
			phase_q <= PH_AWAIT;
		end else begin
			st_q <= st_d;
			phase_q <= phase_d;
		end
	end

endmodule

@@ hw/rtl/pbfct_dp.sv @@
module pbfct_dp #(
	parameter int WORD_BITS = 32,
	parameter int COUNT_BITS = 32
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic [WORD_BITS-1:0]                   sample,
	input  logic [pbfct_pkg::REG_DATA_BITS-1:0]   skip_count,
	input  logic [pbfct_pkg::REG_DATA_BITS-1:0]   done_mask,
	input  pbfct_pkg::dp_cmd_t                     cmd,
	output pbfct_pkg::dp_sts_t                     sts,
	output logic [pbfct_pkg::BIT_INDEX_BITS-1:0]  bit_index,
	output logic [pbfct_pkg::CLOCK_BITS-1:0]      change_clock,
	output logic                                   changed,
	output logic                                   last
);

	localparam int IDX_BITS = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
	localparam logic [IDX_BITS-1:0] IDX_LAST = IDX_BITS'(WORD_BITS - 1);

	logic [WORD_BITS-1:0]             ref_q;
	logic [WORD_BITS-1:0]             seen_q;
	logic [COUNT_BITS-1:0]            ctr_q;
	logic [COUNT_BITS-1:0]            first_q [WORD_BITS];
	logic [IDX_BITS-1:0]              rep_idx_q;

	logic [WORD_BITS-1:0]             change;
	logic [WORD_BITS-1:0]             need;
	logic [pbfct_pkg::CMP_BITS-1:0]   mask_ext;
	logic [pbfct_pkg::CMP_BITS-1:0]   skip_ext;
	logic [pbfct_pkg::CMP_BITS-1:0]   skip_m1;
	logic [pbfct_pkg::CMP_BITS-1:0]   ctr_ext;
	logic [pbfct_pkg::CMP_BITS-1:0]   clk_ext;
	logic [pbfct_pkg::CMP_BITS-1:0]   idx_ext;

	assign change = (sample ^ ref_q) & ~seen_q;
	assign mask_ext = pbfct_pkg::CMP_BITS'(done_mask);
	assign need = mask_ext[WORD_BITS-1:0];
	assign skip_ext = pbfct_pkg::CMP_BITS'(skip_count);
	assign skip_m1 = skip_ext - pbfct_pkg::CMP_BITS'(1);
	assign ctr_ext = pbfct_pkg::CMP_BITS'(ctr_q);

	assign sts.skip_le1 = (skip_count <= pbfct_pkg::REG_DATA_BITS'(1));
	assign sts.skip_reached = (ctr_ext >= skip_m1);
	assign sts.done_hit = (((seen_q | change) & need) == need);
	assign sts.rep_last = (rep_idx_q == IDX_LAST);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_q <= '0;
			seen_q <= '0;
			ctr_q <= '0;
			rep_idx_q <= '0;
		end else if (cmd.clear) begin
			ref_q <= '0;
			seen_q <= '0;
			ctr_q <= '0;
			rep_idx_q <= '0;
		end else begin
			if (cmd.count && (ctr_q != COUNT_MAX)) begin
				ctr_q <= ctr_q + COUNT_BITS'(1);
			end
			if (cmd.load_ref) begin
				ref_q <= sample;
			end
			if (cmd.watch) begin
				seen_q <= seen_q | change;
			end
			if (cmd.rep_step) begin
				rep_idx_q <= rep_idx_q + IDX_BITS'(1);
			end
		end
	end

	// counts are only meaningful where the seen bit is set
	always_ff @(posedge clk) begin
		for (int b = 0; b < WORD_BITS; b++) begin
			if (cmd.watch && change[b]) begin
				first_q[b] <= ctr_q;
			end
		end
	end

	assign clk_ext = seen_q[rep_idx_q] ? pbfct_pkg::CMP_BITS'(first_q[rep_idx_q]) : '0;
	assign idx_ext = pbfct_pkg::CMP_BITS'(rep_idx_q);

	assign bit_index = idx_ext[pbfct_pkg::BIT_INDEX_BITS-1:0];
	assign change_clock = clk_ext[pbfct_pkg::CLOCK_BITS-1:0];
	assign changed = seen_q[rep_idx_q];
	assign last = sts.rep_last;

endmodule

@@ hw/rtl/per_bit_first_change_timer.sv @@
// Per-bit first-change timer. A sample beat (command 0) is taken while not
// reporting; the reference word is the last of the first max(skip_count,1)
// samples, and every later sample stamps its zero-based index, saturating at
// the counter maximum, on each bit that first differs from the reference.
// Once all done_mask bits have been seen, or on an end beat (command 1), the
// block sends WORD_BITS report beats, bit 0 first with last on the final bit,
// one per clock while out_ready is high; the report sequencer walks the
// per-bit count registers one entry a cycle, and input beats are held off
// until the last report beat is taken, after which all capture state is
// cleared. Registers: skip_count at 0x0, done_mask at 0x4; pready is always
// high and writes take effect in the APB access cycle.
module per_bit_first_change_timer #(
	parameter int WORD_BITS = 32,
	parameter int COUNT_BITS = 32
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   psel,
	input  logic                                   penable,
	input  logic                                   pwrite,
	input  logic [pbfct_pkg::REG_ADDR_BITS-1:0]   paddr,
	input  logic [pbfct_pkg::REG_DATA_BITS-1:0]   pwdata,
	output logic [pbfct_pkg::REG_DATA_BITS-1:0]   prdata,
	output logic                                   pready,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic                                   command,
	input  logic [WORD_BITS-1:0]                   sample,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic [pbfct_pkg::BIT_INDEX_BITS-1:0]  bit_index,
	output logic [pbfct_pkg::CLOCK_BITS-1:0]      change_clock,
	output logic                                   changed,
	output logic                                   last
);

	logic [pbfct_pkg::REG_DATA_BITS-1:0] skip_count;
	logic [pbfct_pkg::REG_DATA_BITS-1:0] done_mask;
	pbfct_pkg::dp_cmd_t                   cmd;
	pbfct_pkg::dp_sts_t                   sts;

	pbfct_regs u_regs (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.skip_count (skip_count),
		.done_mask  (done_mask)
	);

	pbfct_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.command   (command),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	pbfct_dp #(
		.WORD_BITS  (WORD_BITS),
		.COUNT_BITS (COUNT_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample       (sample),
		.skip_count   (skip_count),
		.done_mask    (done_mask),
		.cmd          (cmd),
		.sts          (sts),
		.bit_index    (bit_index),
		.change_clock (change_clock),
		.changed      (changed),
		.last         (last)
	);

endmodule

@@ dv/per_bit_first_change_timer_test.sv @@
module per_bit_first_change_timer_test;

	localparam int WORD_BITS = 32;
	localparam int CYCLE_LIMIT = 300000;
	localparam int LONG_HOLD = 400;
	localparam int MAX_SHOWN = 10;

	typedef enum logic [1:0] {
		PH_AWAIT,
		PH_SKIP,
		PH_WATCH
	} capture_phase_t;

	typedef struct packed {
		logic [pbfct_pkg::BIT_INDEX_BITS-1:0] idx;
		logic [pbfct_pkg::CLOCK_BITS-1:0] stamp;
		logic changed;
		logic last;
	} report_t;

	typedef struct packed {
		logic cmd;
		logic [WORD_BITS-1:0] word;
		logic typed;
		logic [WORD_BITS-1:0] t_mask;
		logic [pbfct_pkg::CLOCK_BITS-1:0] t_clock;
	} directed_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [pbfct_pkg::REG_ADDR_BITS-1:0] paddr = '0;
	logic [pbfct_pkg::REG_DATA_BITS-1:0] pwdata = '0;
	logic [pbfct_pkg::REG_DATA_BITS-1:0] prdata;
	logic pready;
	logic in_valid = 1'b0;
	logic in_ready;
	logic command = 1'b0;
	logic [WORD_BITS-1:0] sample = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [pbfct_pkg::BIT_INDEX_BITS-1:0] bit_index;
	logic [pbfct_pkg::CLOCK_BITS-1:0] change_clock;
	logic changed;
	logic last;

	per_bit_first_change_timer dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.command(command),
		.sample(sample),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.bit_index(bit_index),
		.change_clock(change_clock),
		.changed(changed),
		.last(last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// timer state mirror
	logic [pbfct_pkg::REG_DATA_BITS-1:0] cfg_skip;
	logic [pbfct_pkg::REG_DATA_BITS-1:0] cfg_done;
	logic [WORD_BITS-1:0] ref_word;
	logic [pbfct_pkg::CLOCK_BITS-1:0] next_index;
	logic [WORD_BITS-1:0] seen_bits;
	logic [pbfct_pkg::CLOCK_BITS-1:0] first_change [WORD_BITS];
	capture_phase_t capture_phase;
	report_t stamp_report [WORD_BITS];

	report_t expected_reports [$];
	int mismatches = 0;
	int cfg_mismatches = 0;
	int beats_sent = 0;
	int report_beats_checked = 0;
	int reports_due = 0;
	int settings_run = 1;
	int burst_left = 0;
	int cycle_count = 0;
	int hold_left = 0;
	int holds_asked = 0;
	int holds_done = 0;
	int stall_style = 0;
	int style_left = 0;
	int pattern_step = 0;

	directed_row_t directed_rows [15] = '{
		'{1'b1, 32'hdeadbeef, 1'b1, 32'h0000_0000, 32'd0},
		'{1'b0, 32'h0000_0000, 1'b0, 32'h0, 32'd0},
		'{1'b0, 32'hffff_ffff, 1'b1, 32'hffff_ffff, 32'd1},
		'{1'b1, 32'h0000_0000, 1'b1, 32'h0000_0000, 32'd0},
		'{1'b0, 32'hffff_ffff, 1'b0, 32'h0, 32'd0},
		'{1'b0, 32'hffff_ffff, 1'b0, 32'h0, 32'd0},
		'{1'b0, 32'h0000_0001, 1'b0, 32'h0, 32'd0},
		'{1'b0, 32'h0000_0000, 1'b0, 32'h0, 32'd0},
		'{1'b0, 32'ha5a5_a5a5, 1'b0, 32'h0, 32'd0},
		'{1'b0, 32'h5a5a_5a5a, 1'b1, 32'hffff_ffff, 32'd1},
		'{1'b0, 32'h1234_5678, 1'b0, 32'h0, 32'd0},
		'{1'b0, 32'h1234_5679, 1'b0, 32'h0, 32'd0},
		'{1'b0, 32'h9234_5678, 1'b0, 32'h0, 32'd0},
		'{1'b1, 32'hffff_ffff, 1'b0, 32'h0, 32'd0},
		'{1'b1, 32'h0000_0000, 1'b1, 32'h0000_0000, 32'd0}
	};

	task automatic clear_capture();
		ref_word = '0;
		next_index = '0;
		seen_bits = '0;
		foreach (first_change[b]) first_change[b] = '0;
		capture_phase = PH_AWAIT;
	endtask

	task automatic build_report();
		foreach (stamp_report[b]) begin
			stamp_report[b].idx = pbfct_pkg::BIT_INDEX_BITS'(b);
			stamp_report[b].stamp = first_change[b];
			stamp_report[b].changed = seen_bits[b];
			stamp_report[b].last = (b == WORD_BITS - 1);
		end
		clear_capture();
	endtask

	task automatic advance_timer(input logic cmd, input logic [WORD_BITS-1:0] word,
			output bit fired);
		logic [pbfct_pkg::CLOCK_BITS-1:0] n;
		logic [WORD_BITS-1:0] change;
		fired = 1'b0;
		if (cmd) begin
			build_report();
			fired = 1'b1;
		end else begin
			n = next_index;
			if (next_index != '1) next_index = next_index + 1'b1;
			case (capture_phase)
				PH_AWAIT: begin
					ref_word = word;
					capture_phase = (cfg_skip <= 1) ? PH_WATCH : PH_SKIP;
				end
				PH_SKIP: begin
					ref_word = word;
					if (n >= cfg_skip - 1) capture_phase = PH_WATCH;
				end
				default: begin
					change = (word ^ ref_word) & ~seen_bits;
					for (int b = 0; b < WORD_BITS; b++) begin
						if (change[b]) first_change[b] = n;
					end
					seen_bits = seen_bits | change;
					if ((seen_bits & cfg_done) == cfg_done) begin
						build_report();
						fired = 1'b1;
					end
				end
			endcase
		end
	endtask

	task automatic reg_write(input logic idx,
			input logic [pbfct_pkg::REG_DATA_BITS-1:0] value);
		logic [pbfct_pkg::REG_DATA_BITS-1:0] got;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= pbfct_pkg::REG_ADDR_BITS'(4 * int'(idx));
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		// write lands at this edge, read-back setup follows
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(negedge clk);
		got = prdata;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		if (idx == pbfct_pkg::REG_SKIP_COUNT) cfg_skip = value;
		else cfg_done = value;
		if (got !== value) begin
			cfg_mismatches++;
			if (mismatches + cfg_mismatches <= MAX_SHOWN)
				$display("register %0d read back %h, expected %h", idx, got, value);
		end
	endtask

	task automatic send_beat(input logic cmd, input logic [WORD_BITS-1:0] word,
			input logic typed, input logic [WORD_BITS-1:0] t_mask,
			input logic [pbfct_pkg::CLOCK_BITS-1:0] t_clock);
		bit fired;
		report_t item;
		in_valid <= 1'b1;
		command <= cmd;
		sample <= word;
		@(posedge clk);
		while (in_ready !== 1'b1) @(posedge clk);
		beats_sent++;
		advance_timer(cmd, word, fired);
		if (typed) begin
			for (int b = 0; b < WORD_BITS; b++) begin
				item.idx = pbfct_pkg::BIT_INDEX_BITS'(b);
				item.stamp = t_mask[b] ? t_clock : '0;
				item.changed = t_mask[b];
				item.last = (b == WORD_BITS - 1);
				expected_reports.push_back(item);
			end
		end else if (fired) begin
			foreach (stamp_report[b]) expected_reports.push_back(stamp_report[b]);
		end
		if (typed || fired) reports_due++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
				: $urandom_range(0, 8);
		end
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (expected_reports.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	function automatic logic [WORD_BITS-1:0] next_word(
			input logic [WORD_BITS-1:0] prev);
		int r;
		r = $urandom_range(0, 99);
		if (r < 35) return $urandom;
		if (r < 75) return prev ^ (32'h1 << $urandom_range(0, 31));
		if (r < 90) return prev ^ ($urandom & $urandom & $urandom);
		return prev;
	endfunction

	task automatic run_phase(input logic [pbfct_pkg::REG_DATA_BITS-1:0] skip,
			input logic [pbfct_pkg::REG_DATA_BITS-1:0] mask, input int beats,
			input bit long_hold, input bit mid_pause);
		logic [WORD_BITS-1:0] word;
		wait_idle();
		reg_write(pbfct_pkg::REG_SKIP_COUNT, skip);
		reg_write(pbfct_pkg::REG_DONE_MASK, mask);
		settings_run++;
		if (long_hold) holds_asked++;
		word = $urandom;
		for (int i = 0; i < beats; i++) begin
			if (mid_pause && i == beats / 2) wait_idle();
			if ($urandom_range(0, 24) == 0) begin
				send_beat(1'b1, $urandom, 1'b0, '0, '0);
			end else begin
				word = next_word(word);
				send_beat(1'b0, word, 1'b0, '0, '0);
			end
		end
		// end beat flushes whatever is left
		send_beat(1'b1, $urandom, 1'b0, '0, '0);
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else if (holds_done != holds_asked) begin
			holds_done++;
			hold_left = LONG_HOLD;
			out_ready <= 1'b0;
		end else begin
			if (style_left == 0) begin
				stall_style = $urandom_range(0, 3);
				style_left = $urandom_range(20, 200);
			end
			style_left--;
			pattern_step++;
			case (stall_style)
				0: out_ready <= 1'b1;
				1: out_ready <= ($urandom_range(0, 3) != 0);
				2: out_ready <= (pattern_step % 3 != 0);
				default: out_ready <= ($urandom_range(0, 1) == 0);
			endcase
		end
	end

	always @(posedge clk) begin
		report_t got;
		report_t want;
		if (arst_n && out_valid === 1'b1 && out_ready === 1'b1) begin
			got = '{bit_index, change_clock, changed, last};
			if (expected_reports.size() == 0) begin
				mismatches++;
				if (mismatches + cfg_mismatches <= MAX_SHOWN)
					$display({"unexpected report beat: ",
						"idx %0d clock %0d changed %0b last %0b"},
						got.idx, got.stamp, got.changed, got.last);
			end else begin
				want = expected_reports.pop_front();
				report_beats_checked++;
				if (got.idx !== want.idx || got.stamp !== want.stamp
						|| got.changed !== want.changed || got.last !== want.last) begin
					mismatches++;
					if (mismatches + cfg_mismatches <= MAX_SHOWN)
						$display({"report beat mismatch: ",
							"expected idx %0d clock %0d changed %0b last %0b, ",
							"got idx %0d clock %0d changed %0b last %0b"},
							want.idx, want.stamp, want.changed, want.last,
							got.idx, got.stamp, got.changed, got.last);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("run timed out after %0d cycles, %0d report beats pending",
				cycle_count, expected_reports.size());
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		clear_capture();
		cfg_skip = pbfct_pkg::SKIP_COUNT_RESET;
		cfg_done = pbfct_pkg::DONE_MASK_RESET;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		burst_left = $urandom_range(0, 8);

		foreach (directed_rows[i])
			send_beat(directed_rows[i].cmd, directed_rows[i].word,
				directed_rows[i].typed, directed_rows[i].t_mask,
				directed_rows[i].t_clock);

		run_phase(32'h0000_0000, 32'h0000_0000, 40, 1'b1, 1'b0);
		run_phase(32'h0000_0001, 32'hffff_ffff, 80, 1'b0, 1'b1);
		run_phase(32'h0000_0003, $urandom & $urandom, 50, 1'b0, 1'b0);
		run_phase(32'hffff_ffff, 32'hffff_ffff, 30, 1'b0, 1'b0);
		run_phase($urandom_range(2, 20), $urandom, 80, 1'b0, 1'b0);
		run_phase(32'h0000_0000, 32'h8000_0001, 60, 1'b0, 1'b0);
		run_phase(32'h0000_0007, 32'hffff_ffff, 50, 1'b0, 1'b0);

		wait_idle();
		repeat (20) @(posedge clk);
		$display("covered %0d input beats under %0d register settings",
			beats_sent, settings_run);
		$display("checked %0d report beats from %0d reports, %0d mismatches",
			report_beats_checked, reports_due, mismatches + cfg_mismatches);
		if (mismatches == 0 && cfg_mismatches == 0 && expected_reports.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
hw/rtl/pbfct_pkg.sv
hw/rtl/pbfct_regs.sv
hw/rtl/pbfct_ctrl.sv
hw/rtl/pbfct_dp.sv
hw/rtl/per_bit_first_change_timer.sv
dv/per_bit_first_change_timer_test.sv
